// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of clk, off while rst_n is low
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising edge of clk, reset included
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/tcot_pkg.sv
// ----------------------------------------------------------------------------
// tcot_pkg
// shared types and constants of the triangle / circle overlap test
// ----------------------------------------------------------------------------
package tcot_pkg;

    // default coordinate width, signed Q12.4
    localparam int COORD_BITS_DEF = 16;

    // register stages inside one edge unit
    localparam int EDGE_STAGES = 6;

    // edge unit stages plus the output register
    localparam int LATENCY = EDGE_STAGES + 1;

    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_AB     = 3'd1,
        KIND_BC     = 3'd2,
        KIND_CA     = 3'd3,
        KIND_INSIDE = 3'd4
    } hit_kind_t;

    // per-edge result handed to the top level
    typedef struct packed {
        logic hit;      // circle touches this edge
        logic pos;      // cross term strictly positive
        logic neg;      // cross term strictly negative
    } edge_status_t;

endpackage

// File: sv/tcot_edge.sv
// ----------------------------------------------------------------------------
// tcot_edge
// six-stage edge test of one triangle edge u->v against the circle at q
// ----------------------------------------------------------------------------
module tcot_edge
    import tcot_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                          clk,
    input  logic signed [COORD_BITS-1:0]  ux,
    input  logic signed [COORD_BITS-1:0]  uy,
    input  logic signed [COORD_BITS-1:0]  vx,
    input  logic signed [COORD_BITS-1:0]  vy,
    input  logic signed [COORD_BITS-1:0]  qx,
    input  logic signed [COORD_BITS-1:0]  qy,
    input  logic        [2*COORD_BITS-3:0] r_sq,    // aligned with stage 2
    output edge_status_t                  status   // stage 6
);

    localparam int D_W    = COORD_BITS + 1;     // coordinate difference
    localparam int P_W    = 2 * COORD_BITS + 2; // product of two differences
    localparam int S_W    = 2 * COORD_BITS + 3; // sum of two products
    localparam int MAG_W  = 2 * COORD_BITS + 2; // |cross|
    localparam int K      = MAG_W / 2;
    localparam int MH_W   = MAG_W - K;
    localparam int SQ_W   = 2 * MAG_W;          // cross squared
    localparam int R2_W   = 2 * COORD_BITS - 2; // radius squared
    localparam int KR     = R2_W / 2;
    localparam int RH_W   = R2_W - KR;
    localparam int L2_W   = 2 * COORD_BITS + 2; // edge length squared
    localparam int KL     = L2_W / 2;
    localparam int LH_W   = L2_W - KL;
    localparam int RL_W   = R2_W + L2_W;        // r^2 * |e|^2

    // stage 1: differences
    logic signed [D_W-1:0] ex_reg, ey_reg, wx_reg, wy_reg, tx_reg, ty_reg;
    logic signed [D_W-1:0] ex_next, ey_next, wx_next, wy_next, tx_next, ty_next;

    // stage 2: products
    logic signed [P_W-1:0] cra_reg, crb_reg, sqx_reg, sqy_reg;
    logic signed [P_W-1:0] d1a_reg, d1b_reg, d2a_reg, d2b_reg;
    logic signed [P_W-1:0] cra_next, crb_next, sqx_next, sqy_next;
    logic signed [P_W-1:0] d1a_next, d1b_next, d2a_next, d2b_next;

    // stage 3: cross magnitude, length, dot signs
    logic [MAG_W-1:0] mag_reg, mag_next;
    logic [L2_W-1:0]  len2_reg, len2_next;
    logic [R2_W-1:0]  r2_reg;
    logic             pos3_reg, neg3_reg, pos3_next, neg3_next;
    logic             d1neg_reg, d1zero_reg, d2neg_reg, d2zero_reg;
    logic             d1neg_next, d1zero_next, d2neg_next, d2zero_next;
    logic signed [S_W-1:0] cr_diff_ab, cr_diff_ba, d1_sum, d2_sum, len_sum;

    // stage 4: partial products
    logic [2*MH_W-1:0]    pp_hh_reg, pp_hh_next;
    logic [MH_W+K-1:0]    pp_hl_reg, pp_hl_next;
    logic [2*K-1:0]       pp_ll_reg, pp_ll_next;
    logic [RH_W+LH_W-1:0] q_hh_reg, q_hh_next;
    logic [RH_W+KL-1:0]   q_hl_reg, q_hl_next;
    logic [KR+LH_W-1:0]   q_lh_reg, q_lh_next;
    logic [KR+KL-1:0]     q_ll_reg, q_ll_next;
    logic                 nz4_reg, proj4_reg, pos4_reg, neg4_reg;
    logic                 nz4_next, proj4_next;
    logic [MH_W-1:0]      mh;
    logic [K-1:0]         ml;
    logic [RH_W-1:0]      rh;
    logic [KR-1:0]        rl;
    logic [LH_W-1:0]      lh;
    logic [KL-1:0]        ll;

    // stage 5: full squares
    logic [SQ_W-1:0] crsq_reg, crsq_next;
    logic [RL_W-1:0] rlen_reg, rlen_next;
    logic            nz5_reg, proj5_reg, pos5_reg, neg5_reg;

    // stage 6: decision
    edge_status_t status_reg, status_next;

    always_comb
    begin
        ex_next = D_W'(ux) - D_W'(vx);
        ey_next = D_W'(uy) - D_W'(vy);
        wx_next = D_W'(ux) - D_W'(qx);
        wy_next = D_W'(uy) - D_W'(qy);
        tx_next = D_W'(vx) - D_W'(qx);
        ty_next = D_W'(vy) - D_W'(qy);
    end

    always_comb
    begin
        cra_next = P_W'(ex_reg) * P_W'(wy_reg);
        crb_next = P_W'(ey_reg) * P_W'(wx_reg);
        sqx_next = P_W'(ex_reg) * P_W'(ex_reg);
        sqy_next = P_W'(ey_reg) * P_W'(ey_reg);
        d1a_next = P_W'(ex_reg) * P_W'(wx_reg);
        d1b_next = P_W'(ey_reg) * P_W'(wy_reg);
        d2a_next = P_W'(tx_reg) * P_W'(ex_reg);
        d2b_next = P_W'(ty_reg) * P_W'(ey_reg);
    end

    always_comb
    begin
        cr_diff_ab  = S_W'(cra_reg) - S_W'(crb_reg);
        cr_diff_ba  = S_W'(crb_reg) - S_W'(cra_reg);
        d1_sum      = S_W'(d1a_reg) + S_W'(d1b_reg);
        d2_sum      = S_W'(d2a_reg) + S_W'(d2b_reg);
        len_sum     = S_W'(sqx_reg) + S_W'(sqy_reg);
        pos3_next   = cra_reg > crb_reg;
        neg3_next   = cra_reg < crb_reg;
        mag_next    = pos3_next ? cr_diff_ab[MAG_W-1:0] : cr_diff_ba[MAG_W-1:0];
        len2_next   = len_sum[L2_W-1:0];
        d1neg_next  = d1_sum[S_W-1];
        d1zero_next = (d1_sum == '0);
        d2neg_next  = d2_sum[S_W-1];
        d2zero_next = (d2_sum == '0);
    end

    always_comb
    begin
        mh = mag_reg[MAG_W-1:K];
        ml = mag_reg[K-1:0];
        rh = r2_reg[R2_W-1:KR];
        rl = r2_reg[KR-1:0];
        lh = len2_reg[L2_W-1:KL];
        ll = len2_reg[KL-1:0];
        pp_hh_next = (2*MH_W)'(mh) * (2*MH_W)'(mh);
        pp_hl_next = (MH_W+K)'(mh) * (MH_W+K)'(ml);
        pp_ll_next = (2*K)'(ml) * (2*K)'(ml);
        q_hh_next  = (RH_W+LH_W)'(rh) * (RH_W+LH_W)'(lh);
        q_hl_next  = (RH_W+KL)'(rh) * (RH_W+KL)'(ll);
        q_lh_next  = (KR+LH_W)'(rl) * (KR+LH_W)'(lh);
        q_ll_next  = (KR+KL)'(rl) * (KR+KL)'(ll);
        // zero-length edge never hits
        nz4_next   = (len2_reg != '0);
        // product of the two dot terms is zero or negative
        proj4_next = d1zero_reg || d2zero_reg || (d1neg_reg != d2neg_reg);
    end

    always_comb
    begin
        crsq_next = (SQ_W'(pp_hh_reg) << (2 * K))
                  + (SQ_W'(pp_hl_reg) << (K + 1))
                  + SQ_W'(pp_ll_reg);
        rlen_next = (RL_W'(q_hh_reg) << (KR + KL))
                  + (RL_W'(q_hl_reg) << KR)
                  + (RL_W'(q_lh_reg) << KL)
                  + RL_W'(q_ll_reg);
    end

    always_comb
    begin
        status_next.hit = nz5_reg && proj5_reg && (crsq_reg <= SQ_W'(rlen_reg));
        status_next.pos = pos5_reg;
        status_next.neg = neg5_reg;
    end

    always_ff @(posedge clk)
    begin
        ex_reg     <= ex_next;
        ey_reg     <= ey_next;
        wx_reg     <= wx_next;
        wy_reg     <= wy_next;
        tx_reg     <= tx_next;
        ty_reg     <= ty_next;

        cra_reg    <= cra_next;
        crb_reg    <= crb_next;
        sqx_reg    <= sqx_next;
        sqy_reg    <= sqy_next;
        d1a_reg    <= d1a_next;
        d1b_reg    <= d1b_next;
        d2a_reg    <= d2a_next;
        d2b_reg    <= d2b_next;

        mag_reg    <= mag_next;
        len2_reg   <= len2_next;
        r2_reg     <= r_sq;
        pos3_reg   <= pos3_next;
        neg3_reg   <= neg3_next;
        d1neg_reg  <= d1neg_next;
        d1zero_reg <= d1zero_next;
        d2neg_reg  <= d2neg_next;
        d2zero_reg <= d2zero_next;

        pp_hh_reg  <= pp_hh_next;
        pp_hl_reg  <= pp_hl_next;
        pp_ll_reg  <= pp_ll_next;
        q_hh_reg   <= q_hh_next;
        q_hl_reg   <= q_hl_next;
        q_lh_reg   <= q_lh_next;
        q_ll_reg   <= q_ll_next;
        nz4_reg    <= nz4_next;
        proj4_reg  <= proj4_next;
        pos4_reg   <= pos3_reg;
        neg4_reg   <= neg3_reg;

        crsq_reg   <= crsq_next;
        rlen_reg   <= rlen_next;
        nz5_reg    <= nz4_reg;
        proj5_reg  <= proj4_reg;
        pos5_reg   <= pos4_reg;
        neg5_reg   <= neg4_reg;

        status_reg <= status_next;
    end

    assign status = status_reg;

endmodule

// File: sv/triangle_circle_overlap_test.sv
// ----------------------------------------------------------------------------
// triangle_circle_overlap_test
// pipelined triangle versus circle overlap test, one query per cycle
// ----------------------------------------------------------------------------
// done is registered from the end of the valid shift register, which a taken start enters
// throughput: one transaction per cycle, set by the fully pipelined edge units
// busy stays low; the receiver cannot stall and every stage advances each cycle
// reset clears the valid line, the result strobe and the hit outputs; edge data registers are not reset
module triangle_circle_overlap_test
    import tcot_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] ax,
    input  logic signed [COORD_BITS-1:0] ay,
    input  logic signed [COORD_BITS-1:0] bx,
    input  logic signed [COORD_BITS-1:0] by_coord,
    input  logic signed [COORD_BITS-1:0] cx,
    input  logic signed [COORD_BITS-1:0] cy,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    input  logic        [COORD_BITS-2:0] radius,
    output logic                         done,
    output logic                         hit,
    output logic        [2:0]            hit_kind
);

    localparam int R2_W = 2 * COORD_BITS - 2;

    logic                    accept;
    logic [EDGE_STAGES-1:0]  valid_reg, valid_next;
    logic [COORD_BITS-2:0]   r_reg;
    logic [R2_W-1:0]         r_sq_reg, r_sq_next;
    edge_status_t            st_ab, st_bc, st_ca;
    hit_kind_t               kind_next, hit_kind_reg;
    logic                    hit_reg, done_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // radius squared, lined up with stage 2 of the edge units
    assign r_sq_next = R2_W'(r_reg) * R2_W'(r_reg);

    always_ff @(posedge clk)
    begin
        r_reg    <= radius;
        r_sq_reg <= r_sq_next;
    end

    tcot_edge #(.COORD_BITS(COORD_BITS)) u_edge_ab
    (
        .clk    (clk),
        .ux     (ax),
        .uy     (ay),
        .vx     (bx),
        .vy     (by_coord),
        .qx     (px),
        .qy     (py),
        .r_sq   (r_sq_reg),
        .status (st_ab)
    );

    tcot_edge #(.COORD_BITS(COORD_BITS)) u_edge_bc
    (
        .clk    (clk),
        .ux     (bx),
        .uy     (by_coord),
        .vx     (cx),
        .vy     (cy),
        .qx     (px),
        .qy     (py),
        .r_sq   (r_sq_reg),
        .status (st_bc)
    );

    tcot_edge #(.COORD_BITS(COORD_BITS)) u_edge_ca
    (
        .clk    (clk),
        .ux     (cx),
        .uy     (cy),
        .vx     (ax),
        .vy     (ay),
        .qx     (px),
        .qy     (py),
        .r_sq   (r_sq_reg),
        .status (st_ca)
    );

    assign valid_next = {valid_reg[EDGE_STAGES-2:0], accept};

    // first edge in ab, bc, ca order wins, then the strict inside test
    always_comb
    begin
        if (st_ab.hit)
            kind_next = KIND_AB;
        else if (st_bc.hit)
            kind_next = KIND_BC;
        else if (st_ca.hit)
            kind_next = KIND_CA;
        else if ((st_ab.pos && st_bc.pos && st_ca.pos) ||
                 (st_ab.neg && st_bc.neg && st_ca.neg))
            kind_next = KIND_INSIDE;
        else
            kind_next = KIND_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            done_reg     <= 1'b0;
            hit_reg      <= 1'b0;
            hit_kind_reg <= KIND_NONE;
        end
        else
        begin
            valid_reg    <= valid_next;
            done_reg     <= valid_reg[EDGE_STAGES-1];
            hit_reg      <= (kind_next != KIND_NONE);
            hit_kind_reg <= kind_next;
        end
    end

    assign done     = done_reg;
    assign hit      = hit_reg;
    assign hit_kind = hit_kind_reg;

endmodule

// File: sv/tcot_checker.sv
// ----------------------------------------------------------------------------
// tcot_checker
// port-level checks of the overlap test, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcot_checker
    import tcot_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic       done,
    input  logic       hit,
    input  logic [2:0] hit_kind
);

    `ASSERT_CLK_ALWAYS(a_never_busy, !busy, "busy raised on a pipeline that never stalls")

    `ASSERT_CLK(a_done_from_start, done |-> $past(start && !busy, LATENCY), "done without a transaction taken at the fixed latency")

    `ASSERT_CLK(a_start_gives_done, (start && !busy) |-> ##LATENCY done, "transaction taken but no result at the fixed latency")

    `ASSERT_CLK(a_hit_matches_kind, done |-> (hit == (hit_kind != KIND_NONE)), "hit flag disagrees with hit kind")

    `ASSERT_CLK(a_kind_range, done |-> (hit_kind <= KIND_INSIDE), "hit kind outside its codes")

endmodule

bind triangle_circle_overlap_test tcot_checker u_tcot_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .hit      (hit),
    .hit_kind (hit_kind)
);

// File: test/triangle_circle_overlap_test_test.sv
// ----------------------------------------------------------------------------
// triangle_circle_overlap_test_test
// self-checking bench for the pipelined triangle / circle overlap test:
// directed shapes for every hit kind, zero-length edges and extreme
// coordinates, then random full-range and near-triangle queries. each query
// is predicted at acceptance in exact integer arithmetic and compared with
// the strobed result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module triangle_circle_overlap_test_test;
    import tcot_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned MAX_PRINTED = 50;

    typedef struct {
        logic signed [CB-1:0] ax, ay, bx, by_coord, cx, cy, px, py;
        logic        [CB-2:0] radius;
    } query_t;

    typedef struct {
        int unsigned tag;
        logic        hit;
        hit_kind_t   kind;
    } overlap_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic signed [CB-1:0] ax = '0;
    logic signed [CB-1:0] ay = '0;
    logic signed [CB-1:0] bx = '0;
    logic signed [CB-1:0] by_coord = '0;
    logic signed [CB-1:0] cx = '0;
    logic signed [CB-1:0] cy = '0;
    logic signed [CB-1:0] px = '0;
    logic signed [CB-1:0] py = '0;
    logic        [CB-2:0] radius = '0;
    logic                 done;
    logic                 hit;
    logic        [2:0]    hit_kind;

    overlap_t    pending_overlaps[$];
    int unsigned queries_sent = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    bit          idle_on = 1'b1;

    triangle_circle_overlap_test i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .ax       (ax),
        .ay       (ay),
        .bx       (bx),
        .by_coord (by_coord),
        .cx       (cx),
        .cy       (cy),
        .px       (px),
        .py       (py),
        .radius   (radius),
        .done     (done),
        .hit      (hit),
        .hit_kind (hit_kind)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic int sign_of(input longint v);
        if (v > 0)
            return 1;
        else if (v < 0)
            return -1;
        return 0;
    endfunction

    function automatic longint cross_of(input longint ux, input longint uy,
                                        input longint vx, input longint vy,
                                        input longint qx, input longint qy);
        return (ux - vx) * (uy - qy) - (uy - vy) * (ux - qx);
    endfunction

    // circle touches segment u->v: line distance within radius and the
    // center projects onto the segment, compared without any division
    function automatic bit edge_touch(input longint ux, input longint uy,
                                      input longint vx, input longint vy,
                                      input longint qx, input longint qy,
                                      input longint r);
        longint       ex, ey, len2, cr, mag, d1, d2;
        logic [127:0] cross_sq, bound, len_w;
        ex = ux - vx;
        ey = uy - vy;
        len2 = ex * ex + ey * ey;
        if (len2 == 0)
            return 1'b0;
        cr = cross_of(ux, uy, vx, vy, qx, qy);
        mag = (cr < 0) ? -cr : cr;
        cross_sq = mag;
        cross_sq = cross_sq * cross_sq;
        bound = r * r;
        len_w = len2;
        bound = bound * len_w;
        if (cross_sq > bound)
            return 1'b0;
        d1 = ex * (ux - qx) + ey * (uy - qy);
        d2 = (vx - qx) * ex + (vy - qy) * ey;
        return sign_of(d1) * sign_of(d2) <= 0;
    endfunction

    function automatic hit_kind_t predict_overlap(input query_t q);
        longint a_x, a_y, b_x, b_y, c_x, c_y, q_x, q_y, r;
        int     s1, s2, s3;
        a_x = q.ax;
        a_y = q.ay;
        b_x = q.bx;
        b_y = q.by_coord;
        c_x = q.cx;
        c_y = q.cy;
        q_x = q.px;
        q_y = q.py;
        r = q.radius;
        if (edge_touch(a_x, a_y, b_x, b_y, q_x, q_y, r))
            return KIND_AB;
        if (edge_touch(b_x, b_y, c_x, c_y, q_x, q_y, r))
            return KIND_BC;
        if (edge_touch(c_x, c_y, a_x, a_y, q_x, q_y, r))
            return KIND_CA;
        s1 = sign_of(cross_of(a_x, a_y, b_x, b_y, q_x, q_y));
        s2 = sign_of(cross_of(b_x, b_y, c_x, c_y, q_x, q_y));
        s3 = sign_of(cross_of(c_x, c_y, a_x, a_y, q_x, q_y));
        // a zero cross term means on an edge line, never strictly inside
        if ((s1 > 0 && s2 > 0 && s3 > 0) || (s1 < 0 && s2 < 0 && s3 < 0))
            return KIND_INSIDE;
        return KIND_NONE;
    endfunction

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    function automatic query_t make_query(input int a_x, input int a_y,
                                          input int b_x, input int b_y,
                                          input int c_x, input int c_y,
                                          input int q_x, input int q_y,
                                          input int r);
        query_t q;
        q.ax = CB'(a_x);
        q.ay = CB'(a_y);
        q.bx = CB'(b_x);
        q.by_coord = CB'(b_y);
        q.cx = CB'(c_x);
        q.cy = CB'(c_y);
        q.px = CB'(q_x);
        q.py = CB'(q_y);
        q.radius = (CB-1)'(r);
        return q;
    endfunction

    function automatic int rand_between(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // one transaction: hold start until taken, then record the prediction
    task automatic send_query(input query_t q);
        overlap_t expected;
        ax <= q.ax;
        ay <= q.ay;
        bx <= q.bx;
        by_coord <= q.by_coord;
        cx <= q.cx;
        cy <= q.cy;
        px <= q.px;
        py <= q.py;
        radius <= q.radius;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected.tag = queries_sent;
        expected.kind = predict_overlap(q);
        expected.hit = (expected.kind != KIND_NONE);
        pending_overlaps.push_back(expected);
        queries_sent++;
    endtask

    // start low for the requested pause, with junk on the fields that must be ignored
    task automatic pause_start(input int unsigned cycles);
        start <= 1'b0;
        ax <= CB'($urandom);
        ay <= CB'($urandom);
        bx <= CB'($urandom);
        by_coord <= CB'($urandom);
        cx <= CB'($urandom);
        cy <= CB'($urandom);
        px <= CB'($urandom);
        py <= CB'($urandom);
        radius <= (CB-1)'($urandom);
        repeat (cycles)
            @(posedge clk);
    endtask

    task automatic maybe_idle();
        if (idle_on && $urandom_range(99) < 18)
            pause_start($urandom_range(1, 3));
    endtask

    task automatic send_all(input query_t list[$]);
        foreach (list[i])
        begin
            send_query(list[i]);
            maybe_idle();
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // right triangle of side 10.0 (160 in Q12.4), queries covering every hit kind
    task automatic test_hit_kinds();
        query_t list[$];
        list.push_back(make_query(0, 0, 160, 0, 0, 160, 1600, 1600, 16));
        list.push_back(make_query(0, 0, 160, 0, 0, 160, 80, -8, 16));
        list.push_back(make_query(0, 0, 160, 0, 0, 160, 90, 90, 16));
        list.push_back(make_query(0, 0, 160, 0, 0, 160, -8, 80, 16));
        list.push_back(make_query(0, 0, 160, 0, 0, 160, 40, 40, 4));
        // clockwise winding
        list.push_back(make_query(0, 0, 0, 160, 160, 0, 40, 40, 4));
        list.push_back(make_query(0, 0, 160, 0, 0, 160, 40, 40, 0));
        // on the line of ab but past its end
        list.push_back(make_query(0, 0, 160, 0, 0, 160, 320, 0, 16));
        // center on a vertex and on an edge with zero radius
        list.push_back(make_query(0, 0, 160, 0, 0, 160, 0, 0, 0));
        list.push_back(make_query(0, 0, 160, 0, 0, 160, 80, 80, 0));
        send_all(list);
    endtask

    task automatic test_degenerate_shapes();
        query_t list[$];
        // zero-length ab, the center on bc
        list.push_back(make_query(100, 100, 100, 100, 300, 100, 100, 100, 0));
        // zero-length ab, the center on that point only
        list.push_back(make_query(100, 100, 100, 100, 300, 300, 100, 100, 0));
        // every vertex the same point
        list.push_back(make_query(50, -50, 50, -50, 50, -50, 50, -50, 32767));
        // collinear vertices
        list.push_back(make_query(0, 0, 160, 0, 320, 0, 400, 100, 16));
        list.push_back(make_query(0, 0, 160, 0, 320, 0, 240, 0, 0));
        send_all(list);
    endtask

    task automatic test_extreme_coords();
        query_t list[$];
        list.push_back(make_query(-32768, -32768, -32768, -32768, -32768, -32768,
                                  -32768, -32768, 0));
        list.push_back(make_query(-32768, -32768, 32767, -32768, -32768, 32767,
                                  32767, 32767, 32767));
        list.push_back(make_query(32767, 32767, -32768, 32767, 32767, -32768,
                                  -32768, -32768, 32767));
        list.push_back(make_query(-32768, -32768, 32767, -32768, -32768, 32767,
                                  0, 0, 0));
        list.push_back(make_query(-32768, 32767, 32767, 32767, 0, -32768,
                                  32767, -32768, 16384));
        list.push_back(make_query(32767, -32768, -32768, 32767, 32767, 32767,
                                  -32768, -32768, 1));
        send_all(list);
    endtask

    // uniform fields, with some corner values and shared vertices mixed in
    task automatic test_random_full_range(input int unsigned count);
        query_t q;
        int     corner[5];
        corner = '{-32768, -1, 0, 1, 32767};
        for (int unsigned i = 0; i < count; i++)
        begin
            q = make_query($urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom);
            case ($urandom_range(7))
                0:
                begin
                    q.ax = CB'(corner[$urandom_range(4)]);
                    q.by_coord = CB'(corner[$urandom_range(4)]);
                    q.px = CB'(corner[$urandom_range(4)]);
                    q.radius = $urandom_range(1) ? '1 : '0;
                end
                1:
                begin
                    q.cx = q.bx;
                    q.cy = q.by_coord;
                end
                2:
                begin
                    q.px = q.ax;
                    q.py = q.ay;
                end
                default:
                begin
                end
            endcase
            send_query(q);
            maybe_idle();
        end
    endtask

    // local triangles with the center inside or close by and a modest radius
    task automatic test_random_near_shapes(input int unsigned count);
        query_t q;
        int     span, base_x, base_y, w0, w1, w2, q_x, q_y, r;
        int     vx[3], vy[3];
        for (int unsigned i = 0; i < count; i++)
        begin
            // one long stretch of back-to-back transactions
            idle_on = !(i >= 100 && i < 350);
            span = 1 << $urandom_range(2, 11);
            base_x = rand_between(-28000, 28000);
            base_y = rand_between(-28000, 28000);
            for (int k = 0; k < 3; k++)
            begin
                vx[k] = base_x + rand_between(-span, span);
                vy[k] = base_y + rand_between(-span, span);
            end
            if ($urandom_range(19) == 0)
            begin
                vx[2] = vx[1];
                vy[2] = vy[1];
            end
            if ($urandom_range(1))
            begin
                w0 = $urandom_range(1, 8);
                w1 = $urandom_range(0, 8);
                w2 = $urandom_range(0, 8);
                q_x = (w0 * vx[0] + w1 * vx[1] + w2 * vx[2]) / (w0 + w1 + w2);
                q_y = (w0 * vy[0] + w1 * vy[1] + w2 * vy[2]) / (w0 + w1 + w2);
            end
            else
            begin
                q_x = base_x + rand_between(-2 * span, 2 * span);
                q_y = base_y + rand_between(-2 * span, 2 * span);
            end
            if ($urandom_range(3) == 0)
                r = $urandom_range(0, 3);
            else
                r = $urandom_range(0, span / 2);
            q = make_query(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2], q_x, q_y, r);
            send_query(q);
            maybe_idle();
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // result checking, one strobe per transaction, in order
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        overlap_t expected;
        if (rst_n && done)
        begin
            if (pending_overlaps.size() == 0)
                report_mismatch($sformatf("result hit=%0d kind=%0d with no query pending",
                                          hit, hit_kind));
            else
            begin
                expected = pending_overlaps.pop_front();
                if (hit !== expected.hit)
                    report_mismatch($sformatf("query %0d: hit %b, expected %b",
                                              expected.tag, hit, expected.hit));
                if (hit_kind !== expected.kind)
                    report_mismatch($sformatf("query %0d: hit_kind %0d, expected %0d (%s)",
                                              expected.tag, hit_kind, expected.kind,
                                              expected.kind.name()));
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** triangle_circle_overlap_test: FAILED **");
        $finish;
    end

    initial
    begin : main
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        test_hit_kinds();
        test_degenerate_shapes();
        test_extreme_coords();
        test_random_full_range(400);
        test_random_near_shapes(850);
        start <= 1'b0;
        while (pending_overlaps.size() != 0)
            @(posedge clk);
        // catch any stray strobe after the last expected result
        repeat (LATENCY + 4)
            @(posedge clk);
        if (mismatches == 0)
            $display("** triangle_circle_overlap_test: PASSED **");
        else
            $display("** triangle_circle_overlap_test: FAILED **");
        $finish;
    end

endmodule
